// ===== rtl/eil4hp_pkg.sv =====
package eil4hp_pkg;

  localparam int unsigned COUNT_BITS_DEFAULT = 16;

  localparam int unsigned ETH_HDR_LEN   = 14;
  localparam int unsigned MIN_IP_FRAME  = 34;
  localparam int unsigned TCP_HDR_MIN   = 20;
  localparam int unsigned UDP_HDR_LEN   = 8;
  localparam int unsigned IHL_MIN       = 5;

  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IP_VERSION_4  = 4'd4;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;

  localparam int unsigned OFS_ETH_TYPE_HI = 12;
  localparam int unsigned OFS_ETH_TYPE_LO = 13;
  localparam int unsigned OFS_VER_IHL     = 14;
  localparam int unsigned OFS_TTL         = 22;
  localparam int unsigned OFS_PROTO       = 23;
  localparam int unsigned OFS_SRC_FIRST   = 26;
  localparam int unsigned OFS_SRC_LAST    = 29;
  localparam int unsigned OFS_DST_FIRST   = 30;
  localparam int unsigned OFS_DST_LAST    = 33;

  typedef enum logic [1:0] {
    L4_OTHER = 2'd0,
    L4_TCP   = 2'd1,
    L4_UDP   = 2'd2
  } l4_kind_e;

endpackage

// ===== rtl/eth_ipv4_l4_header_parser_top.sv =====
// Channel | Handshake                 | Payload                        | Transaction
// input   | in_valid_i / in_ready_o   | byte_in_i, last_byte_i         | one frame byte
// output  | out_valid_o / out_ready_i | ip_ok_o, l4_kind_o ... data_len_o | one result per frame
// One byte is accepted per cycle while in_ready_o is high.
// The last byte registers the length in len_q and sets pend_q; the result then loads once the output register is free.
// rst_ni clears the byte counter and the valid flags; field registers hold junk.
// in_ready_o drops only while a finished frame waits for a full output register;
// the next frame's first byte is taken in the same cycle the result moves out.
module eth_ipv4_l4_header_parser_top #(
  parameter int unsigned COUNT_BITS = eil4hp_pkg::COUNT_BITS_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_in_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ip_ok_o,
  output logic [1:0]  l4_kind_o,
  output logic        transport_ok_o,
  output logic [7:0]  ttl_o,
  output logic [31:0] src_ip_o,
  output logic [31:0] dst_ip_o,
  output logic [15:0] sport_o,
  output logic [15:0] dport_o,
  output logic [31:0] seq_num_o,
  output logic [31:0] ack_num_o,
  output logic [7:0]  flags_o,
  output logic [15:0] data_len_o
);
  import eil4hp_pkg::*;

  localparam int unsigned CB = COUNT_BITS;
  localparam logic [CB-1:0] CountMax = '1;

  typedef struct packed {
    logic        ip_ok;
    logic [1:0]  l4_kind;
    logic        transport_ok;
    logic [7:0]  ttl;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [7:0]  flags;
    logic [15:0] data_len;
  } result_t;

  logic [CB-1:0] count_q, count_d, len_next, len_q;
  logic          pend_q;
  logic [15:0]   eth_type_q, eth_type_d;
  logic [7:0]    ver_ihl_q, ver_ihl_d;
  logic [7:0]    ttl_q, ttl_d;
  logic [7:0]    proto_q, proto_d;
  logic [31:0]   src_q, src_d;
  logic [31:0]   dst_q, dst_d;
  logic [15:0]   sport_q, sport_d;
  logic [15:0]   dport_q, dport_d;
  logic [31:0]   seq_q, seq_d;
  logic [31:0]   ack_q, ack_d;
  logic [7:0]    flags_q, flags_d;
  logic [3:0]    doff_q, doff_d;

  logic          out_valid_q;
  result_t       out_q, res;

  logic          in_fire, out_free, eval_load, cap_en;
  logic [CB-1:0] t_cap, r_cap;

  assign out_free   = !out_valid_q || out_ready_i;
  assign eval_load  = pend_q && out_free;
  assign in_ready_o = !pend_q || out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign cap_en     = in_fire && (count_q != CountMax);

  assign len_next = (count_q == CountMax) ? CountMax : count_q + CB'(1);
  assign count_d  = in_fire ? (last_byte_i ? '0 : len_next) : count_q;

  assign t_cap = CB'(ETH_HDR_LEN) + CB'({ver_ihl_q[3:0], 2'b00});
  assign r_cap = count_q - t_cap;

  always_comb begin
    eth_type_d = eth_type_q;
    ver_ihl_d  = ver_ihl_q;
    ttl_d      = ttl_q;
    proto_d    = proto_q;
    src_d      = src_q;
    dst_d      = dst_q;
    sport_d    = sport_q;
    dport_d    = dport_q;
    seq_d      = seq_q;
    ack_d      = ack_q;
    flags_d    = flags_q;
    doff_d     = doff_q;
    if (cap_en) begin
      if (count_q == CB'(OFS_ETH_TYPE_HI) || count_q == CB'(OFS_ETH_TYPE_LO)) begin
        eth_type_d = {eth_type_q[7:0], byte_in_i};
      end else if (count_q == CB'(OFS_VER_IHL)) begin
        ver_ihl_d = byte_in_i;
      end else if (count_q == CB'(OFS_TTL)) begin
        ttl_d = byte_in_i;
      end else if (count_q == CB'(OFS_PROTO)) begin
        proto_d = byte_in_i;
      end else if (count_q >= CB'(OFS_SRC_FIRST) && count_q <= CB'(OFS_SRC_LAST)) begin
        src_d = {src_q[23:0], byte_in_i};
      end else if (count_q >= CB'(OFS_DST_FIRST) && count_q <= CB'(OFS_DST_LAST)) begin
        dst_d = {dst_q[23:0], byte_in_i};
      end
      if (count_q > CB'(OFS_VER_IHL) && count_q >= t_cap) begin
        if (r_cap < CB'(2)) begin
          sport_d = {sport_q[7:0], byte_in_i};
        end else if (r_cap < CB'(4)) begin
          dport_d = {dport_q[7:0], byte_in_i};
        end else if (r_cap < CB'(8)) begin
          seq_d = {seq_q[23:0], byte_in_i};
        end else if (r_cap < CB'(12)) begin
          ack_d = {ack_q[23:0], byte_in_i};
        end else if (r_cap == CB'(12)) begin
          doff_d = byte_in_i[7:4];
        end else if (r_cap == CB'(13)) begin
          flags_d = byte_in_i;
        end
      end
    end
  end

  logic [3:0]    ihl;
  logic [CB-1:0] t_ev, hdr_end;
  logic          ip_ok;

  assign ihl     = ver_ihl_q[3:0];
  assign t_ev    = CB'(ETH_HDR_LEN) + CB'({ihl, 2'b00});
  assign hdr_end = t_ev + CB'({doff_q, 2'b00});
  assign ip_ok   = (len_q >= CB'(MIN_IP_FRAME)) && (eth_type_q == ETH_TYPE_IPV4) &&
                   (ver_ihl_q[7:4] == IP_VERSION_4) && (ihl >= 4'(IHL_MIN)) &&
                   (len_q >= t_ev);

  always_comb begin
    res = '0;
    if (ip_ok) begin
      res.ip_ok  = 1'b1;
      res.ttl    = ttl_q;
      res.src_ip = src_q;
      res.dst_ip = dst_q;
      if (proto_q == PROTO_TCP) begin
        res.l4_kind = L4_TCP;
        if (len_q >= t_ev + CB'(TCP_HDR_MIN)) begin
          res.sport   = sport_q;
          res.dport   = dport_q;
          res.seq_num = seq_q;
          res.ack_num = ack_q;
          res.flags   = flags_q;
          if (doff_q >= 4'(IHL_MIN) && len_q >= hdr_end) begin
            res.transport_ok = 1'b1;
            res.data_len     = 16'(len_q - hdr_end);
          end
        end
      end else if (proto_q == PROTO_UDP) begin
        res.l4_kind = L4_UDP;
        if (len_q >= t_ev + CB'(UDP_HDR_LEN)) begin
          res.transport_ok = 1'b1;
          res.sport        = sport_q;
          res.dport        = dport_q;
          res.data_len     = 16'(len_q - (t_ev + CB'(UDP_HDR_LEN)));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire && last_byte_i) begin
        pend_q <= 1'b1;
      end else if (eval_load) begin
        pend_q <= 1'b0;
      end
      if (eval_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    eth_type_q <= eth_type_d;
    ver_ihl_q  <= ver_ihl_d;
    ttl_q      <= ttl_d;
    proto_q    <= proto_d;
    src_q      <= src_d;
    dst_q      <= dst_d;
    sport_q    <= sport_d;
    dport_q    <= dport_d;
    seq_q      <= seq_d;
    ack_q      <= ack_d;
    flags_q    <= flags_d;
    doff_q     <= doff_d;
    if (in_fire && last_byte_i) begin
      len_q <= len_next;
    end
    if (eval_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ip_ok_o        = out_q.ip_ok;
  assign l4_kind_o      = out_q.l4_kind;
  assign transport_ok_o = out_q.transport_ok;
  assign ttl_o          = out_q.ttl;
  assign src_ip_o       = out_q.src_ip;
  assign dst_ip_o       = out_q.dst_ip;
  assign sport_o        = out_q.sport;
  assign dport_o        = out_q.dport;
  assign seq_num_o      = out_q.seq_num;
  assign ack_num_o      = out_q.ack_num;
  assign flags_o        = out_q.flags;
  assign data_len_o     = out_q.data_len;

endmodule

// ===== rtl/eil4hp_checker.sv =====
module eil4hp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        ip_ok_o,
  input logic [1:0]  l4_kind_o,
  input logic        transport_ok_o,
  input logic [7:0]  ttl_o,
  input logic [31:0] src_ip_o,
  input logic [31:0] dst_ip_o,
  input logic [15:0] sport_o,
  input logic [15:0] dport_o,
  input logic [31:0] seq_num_o,
  input logic [31:0] ack_num_o,
  input logic [7:0]  flags_o,
  input logic [15:0] data_len_o
);
  import eil4hp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(src_ip_o) &&
    $stable(data_len_o) && $stable(l4_kind_o) && $stable(seq_num_o))
    else $error("result changed while stalled");

  a_no_ip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ip_ok_o |-> l4_kind_o == L4_OTHER && !transport_ok_o &&
    ttl_o == '0 && src_ip_o == '0 && dst_ip_o == '0 && sport_o == '0 &&
    dport_o == '0 && data_len_o == '0)
    else $error("fields not zero for invalid IP");

  a_transport_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && transport_ok_o |-> ip_ok_o &&
    (l4_kind_o == L4_TCP || l4_kind_o == L4_UDP))
    else $error("transport valid without TCP or UDP");

  a_tcp_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && l4_kind_o != L4_TCP |->
    seq_num_o == '0 && ack_num_o == '0 && flags_o == '0)
    else $error("TCP fields set for non-TCP result");

  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !transport_ok_o |-> data_len_o == '0)
    else $error("payload length without valid transport");

endmodule

bind eth_ipv4_l4_header_parser_top eil4hp_checker u_eil4hp_checker (.*);

// ===== dv/eth_ipv4_l4_header_parser_top_tb.sv =====
`timescale 1ns / 1ps

module eth_ipv4_l4_header_parser_top_tb;
  import eil4hp_pkg::*;

  localparam int unsigned COUNT_BITS    = COUNT_BITS_DEFAULT;
  localparam int unsigned CNT_MAX       = (1 << COUNT_BITS) - 1;
  localparam int unsigned TCP_DOFF_MIN  = TCP_HDR_MIN / 4;
  localparam int unsigned TCP_OFS_DOFF  = 12;
  localparam int unsigned TCP_OFS_FLAGS = 13;
  localparam int unsigned TOTAL_BYTES   = 1600;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned MAX_PRINTS    = 30;

  typedef struct packed {
    logic        ip_ok;
    l4_kind_e    l4_kind;
    logic        transport_ok;
    logic [7:0]  ttl;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [7:0]  flags;
    logic [15:0] data_len;
  } parse_result_t;

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_kind_e;

  class hdr_parse_scoreboard;
    parse_result_t parse_results_q[$];
    int unsigned   errors;
    int unsigned   bytes_taken;
    int unsigned   frames_done;
    int unsigned   results_checked;
    int unsigned   ip_frames;
    int unsigned   tcp_ok_frames;
    int unsigned   udp_ok_frames;

    int unsigned   byte_cnt;
    logic [15:0]   eth_type;
    logic [7:0]    ver_ihl;
    logic [7:0]    ttl_b;
    logic [7:0]    proto;
    logic [31:0]   src_addr;
    logic [31:0]   dst_addr;
    logic [15:0]   sport;
    logic [15:0]   dport;
    logic [31:0]   seq;
    logic [31:0]   ack;
    logic [7:0]    flags;
    logic [3:0]    doff;

    function new();
      errors = 0;
      bytes_taken = 0;
      frames_done = 0;
      results_checked = 0;
      ip_frames = 0;
      tcp_ok_frames = 0;
      udp_ok_frames = 0;
      clear_state();
    endfunction

    function void clear_state();
      byte_cnt = 0;
      eth_type = '0;
      ver_ihl  = '0;
      ttl_b    = '0;
      proto    = '0;
      src_addr = '0;
      dst_addr = '0;
      sport    = '0;
      dport    = '0;
      seq      = '0;
      ack      = '0;
      flags    = '0;
      doff     = '0;
    endfunction

    function void capture_byte(int unsigned idx, logic [7:0] b);
      int unsigned t;
      int unsigned r;
      if (idx == OFS_ETH_TYPE_HI || idx == OFS_ETH_TYPE_LO) begin
        eth_type = {eth_type[7:0], b};
      end else if (idx == OFS_VER_IHL) begin
        ver_ihl = b;
      end else if (idx == OFS_TTL) begin
        ttl_b = b;
      end else if (idx == OFS_PROTO) begin
        proto = b;
      end else if (idx >= OFS_SRC_FIRST && idx <= OFS_SRC_LAST) begin
        src_addr = {src_addr[23:0], b};
      end else if (idx >= OFS_DST_FIRST && idx <= OFS_DST_LAST) begin
        dst_addr = {dst_addr[23:0], b};
      end
      t = ETH_HDR_LEN + 4 * 32'(ver_ihl[3:0]);
      if (idx > OFS_VER_IHL && idx >= t) begin
        r = idx - t;
        if (r < 2) begin
          sport = {sport[7:0], b};
        end else if (r < 4) begin
          dport = {dport[7:0], b};
        end else if (r < 8) begin
          seq = {seq[23:0], b};
        end else if (r < 12) begin
          ack = {ack[23:0], b};
        end else if (r == TCP_OFS_DOFF) begin
          doff = b[7:4];
        end else if (r == TCP_OFS_FLAGS) begin
          flags = b;
        end
      end
    endfunction

    function void parse_byte(logic [7:0] b, logic last);
      int unsigned   len;
      int unsigned   ihl;
      int unsigned   t;
      int unsigned   hdr_end;
      parse_result_t res;
      bytes_taken++;
      if (byte_cnt < CNT_MAX) capture_byte(byte_cnt, b);
      len = (byte_cnt + 1 > CNT_MAX) ? CNT_MAX : byte_cnt + 1;
      byte_cnt = len;
      if (!last) return;
      res = '0;
      ihl = 32'(ver_ihl[3:0]);
      t = ETH_HDR_LEN + 4 * ihl;
      if (len >= MIN_IP_FRAME && eth_type == ETH_TYPE_IPV4 &&
          ver_ihl[7:4] == IP_VERSION_4 && ihl >= IHL_MIN && len >= t) begin
        ip_frames++;
        res.ip_ok  = 1'b1;
        res.ttl    = ttl_b;
        res.src_ip = src_addr;
        res.dst_ip = dst_addr;
        if (proto == PROTO_TCP) begin
          res.l4_kind = L4_TCP;
          if (len >= t + TCP_HDR_MIN) begin
            hdr_end = t + 4 * 32'(doff);
            res.sport   = sport;
            res.dport   = dport;
            res.seq_num = seq;
            res.ack_num = ack;
            res.flags   = flags;
            if (doff >= TCP_DOFF_MIN && len >= hdr_end) begin
              tcp_ok_frames++;
              res.transport_ok = 1'b1;
              res.data_len     = 16'(len - hdr_end);
            end
          end
        end else if (proto == PROTO_UDP) begin
          res.l4_kind = L4_UDP;
          if (len >= t + UDP_HDR_LEN) begin
            udp_ok_frames++;
            res.transport_ok = 1'b1;
            res.sport        = sport;
            res.dport        = dport;
            res.data_len     = 16'(len - (t + UDP_HDR_LEN));
          end
        end
      end
      frames_done++;
      parse_results_q.push_back(res);
      clear_state();
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("MISMATCH: %s", msg);
    endtask

    task compare_field(string name, logic [31:0] got_v, logic [31:0] exp_v);
      if (got_v !== exp_v) begin
        report_mismatch($sformatf("result %0d: %s got %0h expected %0h",
                                  results_checked, name, got_v, exp_v));
      end
    endtask

    task check_result(parse_result_t got);
      parse_result_t exp;
      if (parse_results_q.size() == 0) begin
        report_mismatch("result with no frame pending");
        return;
      end
      exp = parse_results_q.pop_front();
      results_checked++;
      compare_field("ip_ok", 32'(got.ip_ok), 32'(exp.ip_ok));
      compare_field("l4_kind", 32'(got.l4_kind), 32'(exp.l4_kind));
      compare_field("transport_ok", 32'(got.transport_ok), 32'(exp.transport_ok));
      compare_field("ttl", 32'(got.ttl), 32'(exp.ttl));
      compare_field("src_ip", got.src_ip, exp.src_ip);
      compare_field("dst_ip", got.dst_ip, exp.dst_ip);
      compare_field("sport", 32'(got.sport), 32'(exp.sport));
      compare_field("dport", 32'(got.dport), 32'(exp.dport));
      compare_field("seq_num", got.seq_num, exp.seq_num);
      compare_field("ack_num", got.ack_num, exp.ack_num);
      compare_field("flags", 32'(got.flags), 32'(exp.flags));
      compare_field("data_len", 32'(got.data_len), 32'(exp.data_len));
    endtask

    function int unsigned pending_count();
      return parse_results_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  byte_in_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        ip_ok_o;
  logic [1:0]  l4_kind_o;
  logic        transport_ok_o;
  logic [7:0]  ttl_o;
  logic [31:0] src_ip_o;
  logic [31:0] dst_ip_o;
  logic [15:0] sport_o;
  logic [15:0] dport_o;
  logic [31:0] seq_num_o;
  logic [31:0] ack_num_o;
  logic [7:0]  flags_o;
  logic [15:0] data_len_o;

  hdr_parse_scoreboard sb;
  parse_result_t       got_result;
  logic [7:0]          frame_q[$];
  fill_kind_e          fill_kind;
  bit                  idle_enable;
  int unsigned         burst_left;
  bit                  hold_req;
  int unsigned         rx_cycle;
  int unsigned         rx_mode;

  eth_ipv4_l4_header_parser_top #(
    .COUNT_BITS(COUNT_BITS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .byte_in_i     (byte_in_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .ip_ok_o       (ip_ok_o),
    .l4_kind_o     (l4_kind_o),
    .transport_ok_o(transport_ok_o),
    .ttl_o         (ttl_o),
    .src_ip_o      (src_ip_o),
    .dst_ip_o      (dst_ip_o),
    .sport_o       (sport_o),
    .dport_o       (dport_o),
    .seq_num_o     (seq_num_o),
    .ack_num_o     (ack_num_o),
    .flags_o       (flags_o),
    .data_len_o    (data_len_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_result = {ip_ok_o, l4_kind_o, transport_ok_o, ttl_o, src_ip_o, dst_ip_o,
                    sport_o, dport_o, seq_num_o, ack_num_o, flags_o,
                    data_len_o};
      sb.check_result(got_result);
    end
  end

  function automatic logic [7:0] fill_byte();
    case (fill_kind)
      FILL_ZERO: return 8'h00;
      FILL_ONES: return 8'hFF;
      default:   return 8'($urandom);
    endcase
  endfunction

  function automatic void build_frame(logic [15:0] etype, logic [7:0] ver_ihl,
                                      logic [7:0] proto, logic [3:0] doff,
                                      int unsigned tail_len, int unsigned cut);
    int unsigned ihl;
    int unsigned n;
    logic [7:0]  tmp;
    frame_q.delete();
    ihl = 32'(ver_ihl[3:0]);
    repeat (12) frame_q.push_back(fill_byte());
    frame_q.push_back(etype[15:8]);
    frame_q.push_back(etype[7:0]);
    frame_q.push_back(ver_ihl);
    repeat (7) frame_q.push_back(fill_byte());
    frame_q.push_back(fill_byte());
    frame_q.push_back(proto);
    repeat (10) frame_q.push_back(fill_byte());
    if (ihl > IHL_MIN) repeat ((ihl - IHL_MIN) * 4) frame_q.push_back(fill_byte());
    if (proto == PROTO_TCP) begin
      repeat (12) frame_q.push_back(fill_byte());
      tmp = fill_byte();
      frame_q.push_back({doff, tmp[3:0]});
      repeat (7) frame_q.push_back(fill_byte());
      if (doff > TCP_DOFF_MIN) repeat ((doff - TCP_DOFF_MIN) * 4) frame_q.push_back(fill_byte());
    end else if (proto == PROTO_UDP) begin
      repeat (UDP_HDR_LEN) frame_q.push_back(fill_byte());
    end
    repeat (tail_len) frame_q.push_back(fill_byte());
    n = (cut >= frame_q.size()) ? frame_q.size() - 1 : cut;
    repeat (n) void'(frame_q.pop_back());
  endfunction

  function automatic void build_noise(int unsigned len);
    frame_q.delete();
    repeat (len) frame_q.push_back(fill_byte());
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    if (idle_enable && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i  <= 1'b1;
    byte_in_i   <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.parse_byte(b, last);
    @(negedge clk_i);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  task automatic run_frame(logic [15:0] etype, logic [7:0] ver_ihl, logic [7:0] proto,
                           logic [3:0] doff, int unsigned tail_len, int unsigned cut);
    build_frame(etype, ver_ihl, proto, doff, tail_len, cut);
    send_frame();
  endtask

  task automatic run_noise(int unsigned len);
    build_noise(len);
    send_frame();
  endtask

  task automatic run_random_frame();
    int unsigned k;
    logic [7:0]  vi;
    logic [3:0]  doff;
    logic [7:0]  proto;
    k = $urandom_range(0, 99);
    vi = {IP_VERSION_4, ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5};
    doff = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
    proto = ($urandom_range(0, 1) == 0) ? PROTO_TCP : PROTO_UDP;
    if (k < 40) begin
      run_frame(ETH_TYPE_IPV4, vi, PROTO_TCP, doff, $urandom_range(0, 24), 0);
    end else if (k < 65) begin
      run_frame(ETH_TYPE_IPV4, vi, PROTO_UDP, doff, $urandom_range(0, 24), 0);
    end else if (k < 70) begin
      run_frame(ETH_TYPE_IPV4, vi, 8'($urandom), doff, $urandom_range(0, 24), 0);
    end else if (k < 75) begin
      run_frame(ETH_TYPE_IPV4, vi, PROTO_TCP, 4'($urandom_range(0, 4)),
                $urandom_range(0, 24), 0);
    end else if (k < 82) begin
      run_frame(ETH_TYPE_IPV4, vi, proto, doff, $urandom_range(0, 8),
                $urandom_range(1, 40));
    end else if (k < 86) begin
      run_frame(16'($urandom), vi, proto, doff, $urandom_range(0, 8), 0);
    end else if (k < 89) begin
      run_frame(ETH_TYPE_IPV4, {4'($urandom), 4'd5}, proto, doff, $urandom_range(0, 8), 0);
    end else if (k < 92) begin
      run_frame(ETH_TYPE_IPV4, {IP_VERSION_4, 4'($urandom_range(0, 4))}, proto, doff,
                $urandom_range(0, 8), 0);
    end else begin
      run_noise($urandom_range(1, 60));
    end
  endtask

  initial begin
    out_ready_i = 1'b0;
    rx_cycle = 0;
    rx_mode = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      rx_cycle++;
      if (rx_cycle % 256 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        2:       out_ready_i <= (rx_cycle % 5) != 0;
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    #8_000_000;
    $display("Timeout: results still outstanding");
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned n_rand;
    sb = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    byte_in_i   = 8'h00;
    last_byte_i = 1'b0;
    fill_kind   = FILL_RANDOM;
    idle_enable = 1'b1;
    burst_left  = 0;
    hold_req    = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    hold_req = 1'b1;
    fill_kind = FILL_ONES;
    run_noise(1);
    run_frame(ETH_TYPE_IPV4, {IP_VERSION_4, 4'd15}, PROTO_TCP, 4'd15, 3, 0);
    run_frame(ETH_TYPE_IPV4, {IP_VERSION_4, 4'd5}, PROTO_UDP, 4'd5, 2, 0);
    fill_kind = FILL_ZERO;
    run_frame(ETH_TYPE_IPV4, {IP_VERSION_4, 4'd5}, PROTO_TCP, 4'd5, 0, 0);
    run_frame(ETH_TYPE_IPV4, {IP_VERSION_4, 4'd5}, PROTO_UDP, 4'd5, 0, 0);
    fill_kind = FILL_RANDOM;
    run_frame(ETH_TYPE_IPV4, {IP_VERSION_4, 4'd5}, PROTO_TCP, 4'd5, 12, 0);
    run_frame(ETH_TYPE_IPV4, {IP_VERSION_4, 4'd5}, PROTO_TCP, 4'd5, 0, 21);
    run_frame(ETH_TYPE_IPV4, {IP_VERSION_4, 4'd5}, PROTO_TCP, 4'd4, 6, 0);
    run_frame(ETH_TYPE_IPV4, {IP_VERSION_4, 4'd5}, PROTO_TCP, 4'd0, 6, 0);
    run_frame(ETH_TYPE_IPV4, {IP_VERSION_4, 4'd5}, PROTO_TCP, 4'd15, 0, 10);
    run_frame(ETH_TYPE_IPV4, {IP_VERSION_4, 4'd5}, PROTO_TCP, 4'd5, 0, 1);
    run_frame(ETH_TYPE_IPV4, {IP_VERSION_4, 4'd5}, PROTO_UDP, 4'd5, 9, 0);
    run_frame(ETH_TYPE_IPV4, {IP_VERSION_4, 4'd5}, PROTO_UDP, 4'd5, 0, 1);
    run_frame(ETH_TYPE_IPV4, {IP_VERSION_4, 4'd5}, PROTO_UDP, 4'd5, 0, 8);
    run_frame(ETH_TYPE_IPV4, {IP_VERSION_4, 4'd5}, 8'd1, 4'd5, 8, 0);
    run_frame(ETH_TYPE_IPV4, {IP_VERSION_4, 4'd5}, 8'd0, 4'd5, 8, 0);
    run_frame(ETH_TYPE_IPV4, {IP_VERSION_4, 4'd5}, 8'd255, 4'd5, 8, 0);
    run_frame(16'h86DD, {IP_VERSION_4, 4'd5}, PROTO_TCP, 4'd5, 4, 0);
    run_frame(16'h0801, {IP_VERSION_4, 4'd5}, PROTO_UDP, 4'd5, 4, 0);
    run_frame(ETH_TYPE_IPV4, 8'h65, PROTO_TCP, 4'd5, 4, 0);
    run_frame(ETH_TYPE_IPV4, {IP_VERSION_4, 4'd4}, PROTO_UDP, 4'd5, 4, 0);
    run_frame(ETH_TYPE_IPV4, {IP_VERSION_4, 4'd0}, PROTO_UDP, 4'd5, 4, 0);
    run_frame(ETH_TYPE_IPV4, {IP_VERSION_4, 4'd15}, 8'd1, 4'd5, 0, 20);

    n_rand = 0;
    while (sb.bytes_taken < TOTAL_BYTES) begin
      if (n_rand == 4) hold_req = 1'b1;
      idle_enable = ($urandom_range(0, 4) != 0);
      run_random_frame();
      n_rand++;
    end
    in_valid_i <= 1'b0;

    while (sb.pending_count() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Covered %0d frames, %0d bytes, %0d results checked",
             sb.frames_done, sb.bytes_taken, sb.results_checked);
    $display("IP valid %0d, TCP complete %0d, UDP complete %0d, mismatches %0d",
             sb.ip_frames, sb.tcp_ok_frames, sb.udp_ok_frames, sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== eth_ipv4_l4_header_parser_top.f =====
rtl/eil4hp_pkg.sv
rtl/eth_ipv4_l4_header_parser_top.sv
rtl/eil4hp_checker.sv
dv/eth_ipv4_l4_header_parser_top_tb.sv
